/* rtl/spmf_pkg.sv */
// Shared definitions for the strict priority multi-queue block.
// Default sizes, request and status codes. No dependencies.
package spmf_pkg;

   localparam int QUEUE_COUNT_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ITEM_WIDTH_DEF  = 32;

   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // CSR register indexes
   localparam logic REG_ACTIVE_QUEUES = 1'b0;

endpackage

/* rtl/spmf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds until the next read. No dependencies.
module spmf_ram #(
   parameter int WIDTH      = 32,
   parameter int DEPTH      = 128,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [ADDR_WIDTH-1:0] waddr,
   input  logic [WIDTH-1:0]      wdata,
   input  logic                  re,
   input  logic [ADDR_WIDTH-1:0] raddr,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/strict_priority_multi_fifo_core.sv */
// Strict priority multi-queue: a bank of ring FIFOs sharing one slot RAM.
// One item is taken per clock while req_stall is low; its result is held in
// stage 1 and then the result register. While a result waits, the block takes
// one more item into stage 1, then stalls. Enqueue writes the slot RAM at the
// tail of the named queue; dequeue picks the lowest non-empty active queue
// from the pointer registers in the accept cycle and reads its head word from
// the registered-read RAM. Each ring holds QUEUE_DEPTH-1 words. No clearing
// pass is needed after reset. Depends on spmf_pkg and spmf_ram.
module strict_priority_multi_fifo_core #(
   parameter int QUEUE_COUNT = spmf_pkg::QUEUE_COUNT_DEF,
   parameter int QUEUE_DEPTH = spmf_pkg::QUEUE_DEPTH_DEF,
   parameter int ITEM_WIDTH  = spmf_pkg::ITEM_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_type,
   input  logic [2:0]             req_queue_index,
   input  logic [31:0]            req_item_data,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output spmf_pkg::status_type   rsp_status,
   output logic [31:0]            rsp_item_out,
   output logic [2:0]             rsp_source_queue,
   // CSR port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   import spmf_pkg::*;

   localparam int QW      = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int PW      = $clog2(QUEUE_DEPTH);
   localparam int NW      = ($clog2(QUEUE_COUNT + 1) > 4) ? $clog2(QUEUE_COUNT + 1) : 4;
   localparam int RDEPTH  = QUEUE_COUNT << PW;
   localparam int RAW     = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

   // ---------------------------------------------------------------- CSR
   logic [3:0] active_ff, active_in;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_ACTIVE_QUEUES) ? 32'(active_ff) : 32'd0;

   always_comb begin
      active_in = active_ff;
      if (csr_wr && (csr_paddr[2] == REG_ACTIVE_QUEUES)) begin
         active_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   // ---------------------------------------------------------- pointers
   logic [PW-1:0] head_ff [QUEUE_COUNT];
   logic [PW-1:0] tail_ff [QUEUE_COUNT];

   logic [NW-1:0]          n_use;
   logic [QUEUE_COUNT-1:0] ready_q;
   logic [QW-1:0]          pick;
   logic                   any_ready;

   assign n_use = (NW'(active_ff) > NW'(QUEUE_COUNT)) ? NW'(QUEUE_COUNT) : NW'(active_ff);

   always_comb begin
      for (int q = 0; q < QUEUE_COUNT; q++) begin
         ready_q[q] = (head_ff[q] != tail_ff[q]) && (NW'(q) < n_use);
      end
   end

   // lowest-numbered ready queue wins
   always_comb begin
      pick = '0;
      for (int q = QUEUE_COUNT - 1; q >= 0; q--) begin
         if (ready_q[q]) begin
            pick = QW'(q);
         end
      end
   end

   assign any_ready = |ready_q;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
      next_slot = (p == LAST_SLOT) ? '0 : p + PW'(1);
   endfunction

   // ----------------------------------------------------- handshake
   logic       s1_valid_ff, s1_valid_in;
   status_type s1_status_ff;
   logic [2:0] s1_src_ff;
   logic       s1_hit_ff;
   logic       s1_move;
   logic       req_accept;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   logic [31:0] rsp_item_ff;
   logic [2:0]  rsp_src_ff;

   assign s1_move    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   // ------------------------------------------------- request decode
   logic [QW-1:0] enq_q;
   logic          enq_in_range;
   logic          enq_full;
   logic          enq_ok;
   logic          deq_ok;
   status_type    dec_status;
   logic [63:0]   wide_in;

   assign enq_q        = QW'(req_queue_index);
   assign enq_in_range = NW'(req_queue_index) < n_use;
   assign enq_full     = next_slot(tail_ff[enq_q]) == head_ff[enq_q];

   always_comb begin
      enq_ok     = 1'b0;
      deq_ok     = 1'b0;
      dec_status = ST_EMPTY;
      if (req_type == REQ_ENQUEUE) begin
         if (!enq_in_range) begin
            dec_status = ST_BAD_INDEX;
         end else if (enq_full) begin
            dec_status = ST_FULL;
         end else begin
            dec_status = ST_OK;
            enq_ok     = req_accept;
         end
      end else if (any_ready) begin
         dec_status = ST_OK;
         deq_ok     = req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < QUEUE_COUNT; q++) begin
            head_ff[q] <= '0;
            tail_ff[q] <= '0;
         end
      end else begin
         for (int q = 0; q < QUEUE_COUNT; q++) begin
            if (enq_ok && (enq_q == QW'(q))) begin
               tail_ff[q] <= next_slot(tail_ff[q]);
            end
            if (deq_ok && (pick == QW'(q))) begin
               head_ff[q] <= next_slot(head_ff[q]);
            end
         end
      end
   end

   // ---------------------------------------------------------- slot RAM
   logic [RAW-1:0]        ram_waddr, ram_raddr;
   logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata;
   logic [63:0]           wide_out;

   assign wide_in   = 64'(req_item_data);
   assign ram_wdata = wide_in[ITEM_WIDTH-1:0];
   assign ram_waddr = RAW'({enq_q, tail_ff[enq_q]});
   assign ram_raddr = RAW'({pick, head_ff[pick]});

   spmf_ram #(
      .WIDTH      (ITEM_WIDTH),
      .DEPTH      (RDEPTH),
      .ADDR_WIDTH (RAW)
   ) u_slot_ram (
      .clock (clock),
      .we    (enq_ok),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (deq_ok),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // read data holds until the next dequeue, which cannot come before s1 leaves
   assign wide_out = 64'(ram_rdata);

   // ---------------------------------------------------- stage 1 / output
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_move ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_status_ff <= dec_status;
         s1_hit_ff    <= (req_type == REQ_DEQUEUE) && any_ready;
         s1_src_ff    <= ((req_type == REQ_DEQUEUE) && any_ready) ? 3'(pick) : 3'd0;
      end
      if (s1_move && s1_valid_ff) begin
         rsp_status_ff <= s1_status_ff;
         rsp_item_ff   <= s1_hit_ff ? wide_out[31:0] : 32'd0;
         rsp_src_ff    <= s1_src_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_item_out     = rsp_item_ff;
   assign rsp_source_queue = rsp_src_ff;

`ifndef ASSERT_OFF
   // an accepted item always occupies stage 1 on the next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted item missing from stage 1");

   // slot RAM never sees a read and a write in the same cycle
   a_ram_one_port: assert property (@(posedge clock) disable iff (reset)
      !(enq_ok && deq_ok))
      else $error("slot RAM read and write collide");

   // a word leaves only with an ok status
   a_word_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_item_ff == 32'd0))
      else $error("data returned with error status");

   // dequeue only from a queue that held a word
   a_deq_nonempty: assert property (@(posedge clock) disable iff (reset)
      deq_ok |-> (head_ff[pick] != tail_ff[pick]))
      else $error("dequeue from empty queue");
`endif

endmodule
